### rtl/core/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// shared constants and types of the sha-1 message hasher
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] PAD_WORD = 32'h80000000;

  // classified transaction handed from front to back
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } sha1_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
    rotl = (x << s) | (x >> (32 - s));
  endfunction

endpackage

### rtl/core/sha1_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_front
// input side: takes words and queues them, count clamped to four
// ----------------------------------------------------------------------------
module sha1_front
  import sha1_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        is_last,
  output logic        q_valid,
  input  logic        q_ready,
  output sha1_item_t  q_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha1_item_t          mem [DEPTH];
  logic [AW-1:0]       wr_ptr, rd_ptr;
  logic [AW:0]         used;
  logic                push, pop;
  sha1_item_t          item_in;

  assign ready   = (used != (AW+1)'(DEPTH));
  assign q_valid = (used != '0);
  assign push    = valid && ready;
  assign pop     = q_valid && q_ready;
  assign q_item  = mem[rd_ptr];

  always_comb begin
    item_in.data  = data_word;
    item_in.count = (byte_count > 3'd4) ? 3'd4 : byte_count;
    item_in.last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      used <= used + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

endmodule

### rtl/core/sha1_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_back
// padding sequencer, 80-round compression and digest output
// ----------------------------------------------------------------------------
module sha1_back
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  sha1_item_t  q_item,
  output logic        valid,
  input  logic        ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t       state;
  logic [31:0]  sched [16];
  logic [31:0]  hh [5];
  logic [31:0]  a, b, c, d, e;
  logic [3:0]   fill_count;
  logic [63:0]  message_bytes;
  logic [6:0]   round_index;
  logic         padding;    // message ended, pad words pending
  logic         pad_extra;  // 0x80 still to push after a full last word
  logic [2:0]   out_idx;
  logic         len_hi;     // high length word sits in slot 14 of this block
  logic         len_pushed; // block being compressed carries the length

  logic [31:0]  push_data;
  logic         push_en;
  logic [31:0]  keep_mask, w_new, w_cur, f, k, t;
  logic [1:0]   stage;
  logic [3:0]   slot;
  logic [63:0]  bits;

  assign slot = round_index[3:0];
  assign bits = message_bytes << 3;
  assign q_ready = (state == S_IDLE);

  always_comb begin
    keep_mask = ~(32'hFFFFFFFF >> (8 * q_item.count));
    push_en   = 1'b0;
    push_data = q_item.data;
    if (state == S_IDLE && q_valid) begin
      push_en = 1'b1;
      if (q_item.last && q_item.count != 3'd4) begin
        push_data = (q_item.data & keep_mask) | (PAD_WORD >> (8 * q_item.count));
      end
    end else if (state == S_PAD) begin
      push_en = 1'b1;
      if (pad_extra) begin
        push_data = PAD_WORD;
      end else if (fill_count == 4'd14) begin
        push_data = bits[63:32];
      end else if (fill_count == 4'd15 && len_hi) begin
        push_data = bits[31:0];
      end else begin
        push_data = '0;
      end
    end
  end

  always_comb begin
    if (round_index < 7'd20) begin
      stage = 2'd0;
    end else if (round_index < 7'd40) begin
      stage = 2'd1;
    end else if (round_index < 7'd60) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
    case (stage)
      2'd0:    begin f = (b & c) ^ (~b & d);          k = K0; end
      2'd1:    begin f = b ^ c ^ d;                   k = K1; end
      2'd2:    begin f = (b & c) ^ (b & d) ^ (c & d); k = K2; end
      default: begin f = b ^ c ^ d;                   k = K3; end
    endcase
    w_new = rotl(sched[slot + 4'd13] ^ sched[slot + 4'd8] ^ sched[slot + 4'd2]
                 ^ sched[slot], 1);
    w_cur = (round_index >= 7'd16) ? w_new : sched[slot];
    t = rotl(a, 5) + f + e + k + w_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      message_bytes <= '0;
      round_index   <= '0;
      padding       <= 1'b0;
      pad_extra     <= 1'b0;
      out_idx       <= '0;
      hh[0] <= H0_INIT; hh[1] <= H1_INIT; hh[2] <= H2_INIT;
      hh[3] <= H3_INIT; hh[4] <= H4_INIT;
    end else begin
      unique case (state)
        S_IDLE, S_PAD: begin
          if (push_en) begin
            sched[fill_count] <= push_data;
            fill_count <= fill_count + 4'd1;
            if (state == S_IDLE) begin
              if (q_item.last) begin
                message_bytes <= message_bytes + 64'(q_item.count);
                padding   <= 1'b1;
                pad_extra <= (q_item.count == 3'd4);
              end else begin
                message_bytes <= message_bytes + 64'd4;
              end
            end else begin
              pad_extra <= 1'b0;
            end
            if (fill_count == 4'd15) begin
              state       <= S_ROUND;
              round_index <= '0;
              a <= hh[0]; b <= hh[1]; c <= hh[2]; d <= hh[3]; e <= hh[4];
            end else if (state == S_IDLE && q_item.last) begin
              state <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          if (round_index >= 7'd16) begin
            sched[slot] <= w_new;
          end
          e <= d; d <= c; c <= rotl(b, 30); b <= a; a <= t;
          round_index <= round_index + 7'd1;
          if (round_index == 7'd79) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          hh[0] <= hh[0] + a; hh[1] <= hh[1] + b; hh[2] <= hh[2] + c;
          hh[3] <= hh[3] + d; hh[4] <= hh[4] + e;
          fill_count <= '0;
          // done once the block carrying the length has been folded in
          if (padding && !pad_extra && len_pushed) begin
            state   <= S_OUT;
            out_idx <= '0;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (ready) begin
            if (out_idx == 3'd4) begin
              out_idx       <= '0;
              state         <= S_IDLE;
              padding       <= 1'b0;
              message_bytes <= '0;
              hh[0] <= H0_INIT; hh[1] <= H1_INIT; hh[2] <= H2_INIT;
              hh[3] <= H3_INIT; hh[4] <= H4_INIT;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a pad word at slot 15 is the low length word only if slot 14 took the high one
  always_ff @(posedge clk) begin
    if (rst) begin
      len_hi     <= 1'b0;
      len_pushed <= 1'b0;
    end else begin
      if (state == S_PAD && !pad_extra && fill_count == 4'd14) begin
        len_hi <= 1'b1;
      end else if (state == S_PAD && fill_count == 4'd15) begin
        len_hi <= 1'b0;
      end
      if (state == S_PAD && !pad_extra && fill_count == 4'd15 && len_hi) begin
        len_pushed <= 1'b1;
      end else if (state == S_OUT) begin
        len_pushed <= 1'b0;
      end
    end
  end

  assign valid       = (state == S_OUT);
  assign digest_word = hh[out_idx];
  assign word_index  = out_idx;
  assign digest_done = (out_idx == 3'd4);

endmodule

### rtl/core/sha1_message_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_hasher
// sha-1 digest of a stream of big-endian 32-bit message words
// ----------------------------------------------------------------------------
// input channel: valid/ready with data_word, byte_count, is_last. byte_count
// is read only on the last word; counts above four act as four.
// output channel: valid/ready, five transactions per message carrying
// digest_word H0..H4 with word_index 0..4, digest_done on the fifth.
// a small queue parts the input from the hashing engine, so words are taken
// while the engine compresses.
// the engine loads each word into the schedule; every sixteenth word starts
// the 80 rounds and a fold, during which the engine takes no new words.
// the last word adds padding: zero words at one a cycle and one or two more
// compressions, then the digest at one word a cycle while the receiver is ready.
// reset clears the queue, length and chaining words to the initial values.
// a stalled receiver holds the digest word; the engine waits, the queue
// keeps taking words until full.
// ----------------------------------------------------------------------------
module sha1_message_hasher
  import sha1_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_done
);

  logic       q_valid, q_ready;
  sha1_item_t q_item;

  sha1_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .data_word(data_word), .byte_count(byte_count), .is_last(is_last),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sha1_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .valid(out_valid), .ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .digest_done(digest_done)
  );

endmodule
